// ===== sv/asre_pkg.sv =====
// ----------------------------------------------------------------------------
// asre_pkg
// Shared widths, codes, sequencer states and rate snapping for the audio
// sample rate estimator.
// ----------------------------------------------------------------------------
package asre_pkg;

    localparam int CMD_W      = 2;
    localparam int FRAMES_W   = 24;
    localparam int ELAPSED_W  = 32;
    localparam int DRIFT_W    = 24;
    localparam int CODE_W     = 3;
    localparam int EST_W      = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam int MICRO_W    = 20;

    localparam int WINDOW_DEPTH_DEF = 8;

    localparam logic [MICRO_W-1:0]   US_PER_SEC    = 20'd1000000;
    localparam logic [ELAPSED_W-1:0] MAX_GAP_RESET = 32'd1000000;

    typedef logic [CODE_W-1:0] code_t;

    localparam code_t RATE_NONE  = 3'd0;
    localparam code_t RATE_32K   = 3'd1;
    localparam code_t RATE_44K1  = 3'd2;
    localparam code_t RATE_48K   = 3'd3;
    localparam code_t RATE_88K2  = 3'd4;
    localparam code_t RATE_96K   = 3'd5;
    localparam code_t RATE_176K4 = 3'd6;
    localparam code_t RATE_192K  = 3'd7;

    // CMD_NOP is ignored: no state change, last code repeated
    typedef enum logic [CMD_W-1:0] {
        CMD_MEASURE = 2'd0,
        CMD_RESTART = 2'd1,
        CMD_RECOVER = 2'd2,
        CMD_NOP     = 2'd3
    } cmd_t;

    localparam logic [CFG_IDX_W-1:0] REG_FORCED_RATE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_GAP     = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_ACCUM,
        ST_MUL,
        ST_DIV,
        ST_SNAP,
        ST_FINISH
    } state_t;

    // Inclusive upper bounds; the 32k, 44.1k, 88.2k and 176.4k bounds are midpoints to the next standard rate
    localparam logic [EST_W-1:0] TH_NONE  = 32'd16000;
    localparam logic [EST_W-1:0] TH_32K   = 32'((32000 + 44100) / 2);
    localparam logic [EST_W-1:0] TH_44K1  = 32'((44100 + 48000) / 2);
    localparam logic [EST_W-1:0] TH_48K   = 32'((48000 + 64000) / 2);
    localparam logic [EST_W-1:0] TH_88K2  = 32'((88200 + 96000) / 2);
    localparam logic [EST_W-1:0] TH_96K   = 32'((96000 + 128000) / 2);
    localparam logic [EST_W-1:0] TH_176K4 = 32'((176400 + 192000) / 2);

    function automatic code_t snap_code(input logic [EST_W-1:0] hz);
        code_t c;
        if (hz <= TH_NONE)       c = RATE_NONE;
        else if (hz <= TH_32K)   c = RATE_32K;
        else if (hz <= TH_44K1)  c = RATE_44K1;
        else if (hz <= TH_48K)   c = RATE_48K;
        else if (hz <= TH_88K2)  c = RATE_88K2;
        else if (hz <= TH_96K)   c = RATE_96K;
        else if (hz <= TH_176K4) c = RATE_176K4;
        else                     c = RATE_192K;
        return c;
    endfunction

endpackage

// ===== sv/asre_if.sv =====
// ----------------------------------------------------------------------------
// asre_if
// Valid/ready channel interfaces: timing reports, results and register writes.
// ----------------------------------------------------------------------------
interface asre_in_if;
    import asre_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [CMD_W-1:0]           command;
    logic [FRAMES_W-1:0]        frames_captured;
    logic [ELAPSED_W-1:0]       elapsed_us;
    logic signed [DRIFT_W-1:0]  sample_drift;

    modport source (output valid, command, frames_captured, elapsed_us, sample_drift,
                    input ready);
    modport sink   (input valid, command, frames_captured, elapsed_us, sample_drift,
                    output ready);
endinterface

interface asre_out_if;
    import asre_pkg::*;

    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] rate_code;
    logic [CODE_W-1:0] locked_code;
    logic [EST_W-1:0]  estimated_hz;
    logic              window_full;

    modport source (output valid, rate_code, locked_code, estimated_hz, window_full,
                    input ready);
    modport sink   (input valid, rate_code, locked_code, estimated_hz, window_full,
                    output ready);
endinterface

interface asre_cfg_if;
    import asre_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/asre_ram.sv =====
// ----------------------------------------------------------------------------
// asre_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module asre_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/asre_div.sv =====
// ----------------------------------------------------------------------------
// asre_div
// Restoring divider, one quotient bit per cycle, quotient saturated to 32 bits.
// ----------------------------------------------------------------------------
module asre_div #(
    parameter int NUM_W = 47,
    parameter int DEN_W = 35
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [NUM_W-1:0]           num,
    input  logic [DEN_W-1:0]           den,
    output logic                       done,
    output logic [asre_pkg::EST_W-1:0] quotient
);
    import asre_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic             den_zero_reg, den_zero_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;

    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   diff;

    always_comb
    begin
        shifted       = {rem_reg, quo_reg[NUM_W-1]};
        diff          = shifted - {1'b0, den_reg};
        quo_next      = quo_reg;
        rem_next      = rem_reg;
        den_next      = den_reg;
        den_zero_next = den_zero_reg;
        cnt_next      = cnt_reg;
        done_next     = 1'b0;
        if (start)
        begin
            quo_next      = num;
            rem_next      = '0;
            den_next      = den;
            den_zero_next = (den == '0);
            cnt_next      = CNT_W'(NUM_W);
        end
        else if (cnt_reg != '0)
        begin
            if (!diff[DEN_W])
            begin
                rem_next = diff[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        den_reg      <= den_next;
        den_zero_reg <= den_zero_next;
    end

    assign done     = done_reg;
    assign quotient = den_zero_reg          ? '0 :
                      (|quo_reg[NUM_W-1:EST_W]) ? '1 : quo_reg[EST_W-1:0];

endmodule

// ===== sv/audio_sample_rate_estimator_unit.sv =====
// ----------------------------------------------------------------------------
// audio_sample_rate_estimator_unit
// Estimates the audio sample rate from per-period timing reports and snaps it
// to a standard rate code with a lock filter.
//
// Channels: meas takes one timing report per transaction (command, frames,
// elapsed microseconds, sample drift); result returns exactly one result per
// report; cfg writes forced_rate_code (index 0) and max_gap_us (index 1) and
// is always ready.
// An estimated measure report passes through decode, ring update, multiply and
// divider start, the serial divider at one quotient bit per cycle, the divider
// done step, snap and output load. Restart, recover, ignored-command,
// forced-rate and bad-gap reports go from decode straight to the output load.
// No new report is taken until the previous one is through; meas.ready is
// high only while the sequencer is idle.
// The ring lives in two RAMs; entries not yet written read as zero by way of
// the fill flag, so no clearing pass runs after reset.
// Reset: lock and last code go to 48 kHz, ring empty, registers to defaults.
// Result stall: a finished result waits in the output register; the next
// report is still accepted and is processed up to its final load.
// ----------------------------------------------------------------------------
module audio_sample_rate_estimator_unit #(
    parameter int WINDOW_DEPTH = asre_pkg::WINDOW_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    asre_in_if.sink    meas,
    asre_out_if.source result,
    asre_cfg_if.sink   cfg
);
    import asre_pkg::*;

    localparam int POS_W   = $clog2(WINDOW_DEPTH);
    localparam int TSUM_W  = ELAPSED_W + $clog2(WINDOW_DEPTH);
    localparam int FSUM_W  = FRAMES_W + $clog2(WINDOW_DEPTH);
    localparam int PROD_W  = FSUM_W + MICRO_W;
    localparam int AGREE_W = $clog2(WINDOW_DEPTH + 1);
    localparam int ACT_W   = FRAMES_W + 2;

    state_t                    state_reg, state_next;
    cmd_t                      cmd_reg, cmd_next;
    logic [FRAMES_W-1:0]       frames_reg, frames_next;
    logic [ELAPSED_W-1:0]      elapsed_reg, elapsed_next;
    logic signed [DRIFT_W-1:0] drift_reg, drift_next;
    logic [FRAMES_W-1:0]       actual_reg, actual_next;

    logic [POS_W-1:0]          pos_reg, pos_next;
    logic                      filled_reg, filled_next;
    logic [TSUM_W-1:0]         time_sum_reg, time_sum_next;
    logic [FSUM_W-1:0]         frame_sum_reg, frame_sum_next;
    code_t                     locked_reg, locked_next;
    code_t                     cand_reg, cand_next;
    logic [AGREE_W-1:0]        agree_reg, agree_next;
    code_t                     last_reg, last_next;

    code_t                     forced_reg, forced_next;
    logic [ELAPSED_W-1:0]      max_gap_reg, max_gap_next;

    code_t                     res_code_reg, res_code_next;
    logic [EST_W-1:0]          res_est_reg, res_est_next;
    logic                      res_full_reg, res_full_next;

    logic                      out_valid_reg, out_valid_next;
    code_t                     out_code_reg, out_code_next;
    code_t                     out_locked_reg, out_locked_next;
    logic [EST_W-1:0]          out_est_reg, out_est_next;
    logic                      out_full_reg, out_full_next;

    logic signed [ACT_W-1:0]   diff_s;
    logic [ELAPSED_W-1:0]      old_time;
    logic [FRAMES_W-1:0]       old_frames;
    logic [FSUM_W-1:0]         mul_a;
    logic                      ring_we;
    logic                      div_start;
    logic [PROD_W-1:0]         div_num;
    logic [TSUM_W-1:0]         div_den;
    logic                      div_done;
    logic [EST_W-1:0]          div_q;
    code_t                     iso;
    logic [AGREE_W-1:0]        agree_inc;

    asre_ram #(.WIDTH(ELAPSED_W), .DEPTH(WINDOW_DEPTH)) u_time_ring (
        .clk   (clk),
        .we    (ring_we),
        .waddr (pos_reg),
        .wdata (elapsed_reg),
        .raddr (pos_reg),
        .rdata (old_time)
    );

    asre_ram #(.WIDTH(FRAMES_W), .DEPTH(WINDOW_DEPTH)) u_frame_ring (
        .clk   (clk),
        .we    (ring_we),
        .waddr (pos_reg),
        .wdata (actual_reg),
        .raddr (pos_reg),
        .rdata (old_frames)
    );

    asre_div #(.NUM_W(PROD_W), .DEN_W(TSUM_W)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (div_num),
        .den      (div_den),
        .done     (div_done),
        .quotient (div_q)
    );

    assign meas.ready = (state_reg == ST_IDLE);
    assign cfg.ready  = 1'b1;

    assign result.valid        = out_valid_reg;
    assign result.rate_code    = out_code_reg;
    assign result.locked_code  = out_locked_reg;
    assign result.estimated_hz = out_est_reg;
    assign result.window_full  = out_full_reg;

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        frames_next     = frames_reg;
        elapsed_next    = elapsed_reg;
        drift_next      = drift_reg;
        actual_next     = actual_reg;
        pos_next        = pos_reg;
        filled_next     = filled_reg;
        time_sum_next   = time_sum_reg;
        frame_sum_next  = frame_sum_reg;
        locked_next     = locked_reg;
        cand_next       = cand_reg;
        agree_next      = agree_reg;
        last_next       = last_reg;
        forced_next     = forced_reg;
        max_gap_next    = max_gap_reg;
        res_code_next   = res_code_reg;
        res_est_next    = res_est_reg;
        res_full_next   = res_full_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        out_code_next   = out_code_reg;
        out_locked_next = out_locked_reg;
        out_est_next    = out_est_reg;
        out_full_next   = out_full_reg;

        ring_we   = 1'b0;
        div_start = 1'b0;
        mul_a     = filled_reg ? frame_sum_reg : FSUM_W'(actual_reg);
        div_num   = PROD_W'(mul_a) * PROD_W'(US_PER_SEC);
        div_den   = filled_reg ? time_sum_reg : TSUM_W'(elapsed_reg);
        diff_s    = $signed({2'b00, frames_reg}) - $signed(ACT_W'(drift_reg));
        iso       = snap_code(res_est_reg);
        agree_inc = agree_reg + 1'b1;

        if (cfg.valid)
        begin
            case (cfg.index)
                REG_FORCED_RATE: forced_next  = cfg.data[CODE_W-1:0];
                REG_MAX_GAP:     max_gap_next = cfg.data[ELAPSED_W-1:0];
                default:         ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (meas.valid)
                begin
                    cmd_next     = cmd_t'(meas.command);
                    frames_next  = meas.frames_captured;
                    elapsed_next = meas.elapsed_us;
                    drift_next   = meas.sample_drift;
                    state_next   = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                res_est_next  = '0;
                res_full_next = 1'b0;
                state_next    = ST_FINISH;
                if (diff_s[ACT_W-1])
                begin
                    actual_next = '0;
                end
                else if (|diff_s[ACT_W-2:FRAMES_W])
                begin
                    actual_next = '1;
                end
                else
                begin
                    actual_next = diff_s[FRAMES_W-1:0];
                end
                case (cmd_reg)
                    CMD_RESTART:
                    begin
                        locked_next   = RATE_NONE;
                        cand_next     = RATE_NONE;
                        agree_next    = '0;
                        res_code_next = last_reg;
                    end
                    CMD_RECOVER:
                    begin
                        locked_next   = RATE_48K;
                        last_next     = RATE_48K;
                        res_code_next = RATE_48K;
                    end
                    CMD_MEASURE:
                    begin
                        if (forced_reg != RATE_NONE)
                        begin
                            locked_next   = forced_reg;
                            last_next     = forced_reg;
                            res_code_next = forced_reg;
                        end
                        else if (elapsed_reg == '0 || elapsed_reg > max_gap_reg)
                        begin
                            last_next     = RATE_NONE;
                            res_code_next = RATE_NONE;
                        end
                        else
                        begin
                            state_next = ST_ACCUM;
                        end
                    end
                    default:
                    begin
                        res_code_next = last_reg;
                    end
                endcase
            end
            ST_ACCUM:
            begin
                // unwritten ring entries count as zero until the first wrap
                ring_we        = 1'b1;
                time_sum_next  = time_sum_reg
                               - (filled_reg ? TSUM_W'(old_time) : '0)
                               + TSUM_W'(elapsed_reg);
                frame_sum_next = frame_sum_reg
                               - (filled_reg ? FSUM_W'(old_frames) : '0)
                               + FSUM_W'(actual_reg);
                if (pos_reg == POS_W'(WINDOW_DEPTH - 1))
                begin
                    pos_next    = '0;
                    filled_next = 1'b1;
                end
                else
                begin
                    pos_next = pos_reg + 1'b1;
                end
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    res_est_next  = div_q;
                    res_full_next = filled_reg;
                    state_next    = ST_SNAP;
                end
            end
            ST_SNAP:
            begin
                res_code_next = iso;
                last_next     = iso;
                if (iso != locked_reg)
                begin
                    if (cand_reg != iso)
                    begin
                        cand_next = iso;
                        agree_inc = AGREE_W'(1);
                    end
                    if (agree_inc >= AGREE_W'(WINDOW_DEPTH))
                    begin
                        locked_next = iso;
                        agree_next  = '0;
                    end
                    else
                    begin
                        agree_next    = agree_inc;
                        res_code_next = last_reg;
                        last_next     = last_reg;
                    end
                end
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_code_next   = res_code_reg;
                    out_locked_next = locked_reg;
                    out_est_next    = res_est_reg;
                    out_full_next   = res_full_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            filled_reg    <= 1'b0;
            time_sum_reg  <= '0;
            frame_sum_reg <= '0;
            locked_reg    <= RATE_48K;
            cand_reg      <= RATE_NONE;
            agree_reg     <= '0;
            last_reg      <= RATE_48K;
            forced_reg    <= RATE_NONE;
            max_gap_reg   <= MAX_GAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            filled_reg    <= filled_next;
            time_sum_reg  <= time_sum_next;
            frame_sum_reg <= frame_sum_next;
            locked_reg    <= locked_next;
            cand_reg      <= cand_next;
            agree_reg     <= agree_next;
            last_reg      <= last_next;
            forced_reg    <= forced_next;
            max_gap_reg   <= max_gap_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        frames_reg     <= frames_next;
        elapsed_reg    <= elapsed_next;
        drift_reg      <= drift_next;
        actual_reg     <= actual_next;
        res_code_reg   <= res_code_next;
        res_est_reg    <= res_est_next;
        res_full_reg   <= res_full_next;
        out_code_reg   <= out_code_next;
        out_locked_reg <= out_locked_next;
        out_est_reg    <= out_est_next;
        out_full_reg   <= out_full_next;
    end

`ifndef ASSERT_OFF
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (meas.valid && meas.ready) |=> !meas.ready)
        else $error("report accepted while sequencer busy");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside divide state");

    a_window_time_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL && filled_reg) |-> (time_sum_reg != '0))
        else $error("window time sum is zero");

    a_agree_bound: assert property (@(posedge clk) disable iff (!rst_n)
        agree_reg < AGREE_W'(WINDOW_DEPTH))
        else $error("agree count reached window depth without lock");
`endif

endmodule

// ===== verif/rate_report_check.sv =====
// ----------------------------------------------------------------------------
// rate_report_check
// Watches the report, result and register channels of the sample rate
// estimator. Keeps its own copy of the ring, the lock filter and the
// registers, predicts one result per accepted report and compares every
// accepted result against the oldest prediction.
// ----------------------------------------------------------------------------
module rate_report_check #(
    parameter int WINDOW = asre_pkg::WINDOW_DEPTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    asre_in_if   meas,
    asre_out_if  result,
    asre_cfg_if  cfg,
    output int   fail_count,
    output int   pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import asre_pkg::*;

    typedef struct packed {
        code_t            rate;
        code_t            locked;
        logic [EST_W-1:0] hz;
        logic             full;
    } rate_report_t;

    // upper bound of each code, code 0 up to code 6
    localparam logic [EST_W-1:0] RATE_EDGE [7] = '{
        32'd16000, 32'd38050, 32'd46050, 32'd56000, 32'd92100, 32'd112000, 32'd184200
    };

    code_t                forced_cfg;
    logic [ELAPSED_W-1:0] gap_limit;

    logic [ELAPSED_W-1:0] time_hist [WINDOW];
    logic [FRAMES_W-1:0]  frame_hist [WINDOW];
    int                   slot;
    bit                   wrapped;
    logic [63:0]          time_total;
    logic [63:0]          frame_total;
    code_t                locked_now;
    code_t                candidate;
    int                   agree_run;
    code_t                last_reported;

    rate_report_t         expected_reports [$];
    rate_report_t         want;
    int                   errors;

    function automatic code_t nearest_rate(logic [EST_W-1:0] hz);
        code_t c;
        int    i;
        c = RATE_NONE;
        for (i = 0; i < 7; i++)
        begin
            if (hz > RATE_EDGE[i])
                c = code_t'(i + 1);
        end
        return c;
    endfunction

    function automatic rate_report_t predict_report(
        logic [CMD_W-1:0]          cmd,
        logic [FRAMES_W-1:0]       frames,
        logic [ELAPSED_W-1:0]      elapsed,
        logic signed [DRIFT_W-1:0] drift
    );
        rate_report_t        r;
        logic signed [25:0]  net;
        logic [FRAMES_W-1:0] net_sat;
        logic [63:0]         quotient;
        code_t               snapped;
        r = '0;
        case (cmd)
            CMD_RESTART:
            begin
                locked_now = RATE_NONE;
                candidate  = RATE_NONE;
                agree_run  = 0;
                r.rate     = last_reported;
            end
            CMD_RECOVER:
            begin
                last_reported = RATE_48K;
                locked_now    = RATE_48K;
                r.rate        = RATE_48K;
            end
            CMD_MEASURE:
            begin
                if (forced_cfg != RATE_NONE)
                begin
                    locked_now    = forced_cfg;
                    r.rate        = forced_cfg;
                    last_reported = forced_cfg;
                end
                else if (elapsed == 0 || elapsed > gap_limit)
                begin
                    r.rate        = RATE_NONE;
                    last_reported = RATE_NONE;
                end
                else
                begin
                    net = $signed({2'b00, frames}) - drift;
                    if (net < 0)
                        net_sat = '0;
                    else if (net > 26'sd16777215)
                        net_sat = '1;
                    else
                        net_sat = net[FRAMES_W-1:0];

                    time_total  = time_total - time_hist[slot] + elapsed;
                    frame_total = frame_total - frame_hist[slot] + net_sat;
                    time_hist[slot]  = elapsed;
                    frame_hist[slot] = net_sat;
                    slot++;
                    if (slot >= WINDOW)
                    begin
                        slot    = 0;
                        wrapped = 1'b1;
                    end

                    if (wrapped)
                    begin
                        quotient = (time_total == 0) ? 64'd0
                                 : (frame_total * 64'd1000000) / time_total;
                        r.full = 1'b1;
                    end
                    else
                        quotient = (64'(net_sat) * 64'd1000000) / 64'(elapsed);
                    r.hz = (quotient > 64'hFFFF_FFFF) ? '1 : quotient[EST_W-1:0];

                    snapped = nearest_rate(r.hz);
                    r.rate  = snapped;
                    if (snapped != locked_now)
                    begin
                        if (candidate != snapped)
                        begin
                            candidate = snapped;
                            agree_run = 0;
                        end
                        agree_run++;
                        if (agree_run >= WINDOW)
                        begin
                            locked_now = candidate;
                            agree_run  = 0;
                        end
                        else
                            r.rate = last_reported;
                    end
                    last_reported = r.rate;
                end
            end
            default:
                r.rate = last_reported;
        endcase
        r.locked = locked_now;
        return r;
    endfunction

    function automatic int field_errors(string field, logic [31:0] exp_val,
                                        logic [31:0] act_val);
        if (exp_val === act_val)
            return 0;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_val,
                 act_val);
        return 1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            forced_cfg = RATE_NONE;
            gap_limit  = MAX_GAP_RESET;
            for (int i = 0; i < WINDOW; i++)
            begin
                time_hist[i]  = '0;
                frame_hist[i] = '0;
            end
            slot          = 0;
            wrapped       = 1'b0;
            time_total    = '0;
            frame_total   = '0;
            locked_now    = RATE_48K;
            candidate     = RATE_NONE;
            agree_run     = 0;
            last_reported = RATE_48K;
            expected_reports.delete();
            errors        = 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                if (expected_reports.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %0d %0d %0d %0d",
                             $time, result.rate_code, result.locked_code,
                             result.estimated_hz, result.window_full);
                    errors++;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    errors += field_errors("rate_code", want.rate, result.rate_code);
                    errors += field_errors("locked_code", want.locked, result.locked_code);
                    errors += field_errors("estimated_hz", want.hz, result.estimated_hz);
                    errors += field_errors("window_full", want.full, result.window_full);
                end
            end
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == REG_FORCED_RATE)
                    forced_cfg = cfg.data[CODE_W-1:0];
                else
                    gap_limit = cfg.data;
            end
            if (meas.valid && meas.ready)
                expected_reports.push_back(predict_report(meas.command, meas.frames_captured,
                                                          meas.elapsed_us, meas.sample_drift));
        end
        fail_count <= errors;
        pending    <= expected_reports.size();
    end

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the audio sample rate estimator: directed corner reports, then
// rate runs mixed with noise, bad gaps and commands under several register
// settings, with random stalls on both channels. Verdict from the checker.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import asre_pkg::*;

    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 64;
    localparam int STD_RATE_HZ [8] = '{8000, 32000, 44100, 48000, 88200, 96000,
                                       176400, 192000};

    logic           clk;
    logic           rst_n;
    logic           idle_on;
    logic [1:0]     ready_hold;
    bit             quiet;
    logic [31:0]    gap_setting;
    int             fails;
    int             pending_reports;
    int             stall_cycles;

    asre_in_if  meas_ch ();
    asre_out_if result_ch ();
    asre_cfg_if cfg_ch ();

    audio_sample_rate_estimator_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .meas   (meas_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    rate_report_check report_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .meas       (meas_ch),
        .result     (result_ch),
        .cfg        (cfg_ch),
        .fail_count (fails),
        .pending    (pending_reports)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            ready_hold      <= '0;
        end
        else if (ready_hold != 0)
        begin
            result_ch.ready <= 1'b0;
            ready_hold      <= ready_hold - 1'b1;
        end
        else if (idle_on && $urandom_range(0, 4) == 0)
        begin
            result_ch.ready <= 1'b0;
            ready_hold      <= 2'($urandom_range(0, 2));
        end
        else
            result_ch.ready <= 1'b1;
    end

    initial
    begin
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (meas_ch.valid && meas_ch.ready)
                || (result_ch.valid && result_ch.ready) || (cfg_ch.valid && cfg_ch.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("tb_top NOT OK");
        $finish;
    end

    task automatic send_report(cmd_t cmd, logic [FRAMES_W-1:0] frames,
                               logic [ELAPSED_W-1:0] elapsed,
                               logic signed [DRIFT_W-1:0] drift);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            meas_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        meas_ch.valid           <= 1'b1;
        meas_ch.command         <= cmd;
        meas_ch.frames_captured <= frames;
        meas_ch.elapsed_us      <= elapsed;
        meas_ch.sample_drift    <= drift;
        @(posedge clk);
        while (!meas_ch.ready) @(posedge clk);
    endtask

    task automatic drain_reports();
        meas_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_reports != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(code_t forced, logic [31:0] gap);
        drain_reports();
        write_register(REG_FORCED_RATE, {29'd0, forced});
        write_register(REG_MAX_GAP, gap);
        gap_setting = gap;
    endtask

    task automatic send_mixed_reports(int count);
        int          sent;
        int          kind;
        int          run_len;
        int          rate_hz;
        int          period;
        int          elapsed;
        longint      frames;
        logic [31:0] bad_gap;
        cmd_t        cmd_pick;
        sent = 0;
        while (sent < count)
        begin
            kind = $urandom_range(0, 99);
            if (!quiet)
                idle_on <= ($urandom_range(0, 3) != 0);
            if (kind < 70)
            begin
                // steady stream at one standard rate with small jitter
                rate_hz = STD_RATE_HZ[$urandom_range(0, 7)];
                run_len = $urandom_range(4, 24);
                period  = $urandom_range(200, 25000);
                repeat (run_len)
                begin
                    elapsed = period + $urandom_range(0, 40) - 20;
                    frames  = (longint'(rate_hz) * elapsed) / 1000000
                              + $urandom_range(0, 4) - 2;
                    if (frames < 0)
                        frames = 0;
                    send_report(CMD_MEASURE, frames[FRAMES_W-1:0], elapsed,
                                DRIFT_W'($urandom_range(0, 8) - 4));
                    sent++;
                end
            end
            else if (kind < 85)
            begin
                case ($urandom_range(0, 2))
                    0:       elapsed = $urandom;
                    1:       elapsed = 1 + ($urandom % gap_setting);
                    default: elapsed = $urandom_range(1, 100);
                endcase
                send_report(CMD_MEASURE, FRAMES_W'($urandom), elapsed, DRIFT_W'($urandom));
                sent++;
            end
            else if (kind < 95)
            begin
                if (gap_setting == 32'hFFFF_FFFF || $urandom_range(0, 1) == 0)
                    bad_gap = '0;
                else if (gap_setting > 32'hFFFF_0000)
                    bad_gap = gap_setting + 1;
                else
                    bad_gap = gap_setting + $urandom_range(1, 65535);
                send_report(CMD_MEASURE, FRAMES_W'($urandom), bad_gap, DRIFT_W'($urandom));
                sent++;
            end
            else
            begin
                case ($urandom_range(0, 2))
                    0:       cmd_pick = CMD_RESTART;
                    1:       cmd_pick = CMD_RECOVER;
                    default: cmd_pick = CMD_NOP;
                endcase
                send_report(cmd_pick, FRAMES_W'($urandom), $urandom, DRIFT_W'($urandom));
                sent++;
            end
        end
    endtask

    initial
    begin
        rst_n                   <= 1'b0;
        idle_on                 <= 1'b0;
        meas_ch.valid           <= 1'b0;
        meas_ch.command         <= CMD_MEASURE;
        meas_ch.frames_captured <= '0;
        meas_ch.elapsed_us      <= '0;
        meas_ch.sample_drift    <= '0;
        cfg_ch.valid            <= 1'b0;
        cfg_ch.index            <= REG_FORCED_RATE;
        cfg_ch.data             <= '0;
        quiet       = 1'b0;
        gap_setting = MAX_GAP_RESET;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        idle_on <= 1'b1;

        // 48k at lock, then a 44.1k run long enough to move the lock
        send_report(CMD_MEASURE, 24'd480, 32'd10000, 24'sd0);
        repeat (9) send_report(CMD_MEASURE, 24'd441, 32'd10000, 24'sd0);
        send_report(CMD_MEASURE, 24'd0, MAX_GAP_RESET, 24'sd0);
        send_report(CMD_MEASURE, 24'd480, MAX_GAP_RESET + 1, 24'sd0);
        send_report(CMD_MEASURE, 24'd480, 32'd0, 24'sd0);
        send_report(CMD_MEASURE, 24'hFF_FFFF, 32'hFFFF_FFFF, 24'sd8388607);
        send_report(CMD_MEASURE, 24'hFF_FFFF, 32'd1, -24'sd8388608);
        send_report(CMD_MEASURE, 24'd0, 32'd1000, 24'sd8388607);
        send_report(CMD_MEASURE, 24'hFF_FFFF, 32'd1000, 24'sd8388607);
        send_report(CMD_NOP, 24'd480, 32'd10000, 24'sd0);
        send_report(CMD_RESTART, 24'd0, 32'd0, 24'sd0);
        send_report(CMD_NOP, 24'd0, 32'd0, 24'sd0);
        send_report(CMD_MEASURE, 24'd960, 32'd20000, -24'sd1);
        send_report(CMD_RECOVER, 24'hFF_FFFF, 32'hFFFF_FFFF, -24'sd1);
        send_report(CMD_MEASURE, 24'd1920, 32'd10000, 24'sd0);

        send_mixed_reports(480);
        set_config(RATE_192K, 32'd1);
        send_mixed_reports(40);
        set_config(RATE_NONE, 32'd1);
        send_mixed_reports(60);
        set_config(RATE_NONE, 32'hFFFF_FFFF);
        send_mixed_reports(300);
        set_config(RATE_48K, 32'hFFFF_FFFF);
        send_mixed_reports(30);
        set_config(RATE_NONE, 32'd20000);
        send_mixed_reports(300);
        set_config(RATE_NONE, MAX_GAP_RESET);
        quiet = 1'b1;
        idle_on <= 1'b0;
        send_mixed_reports(250);
        drain_reports();

        if (fails == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
